// ===== design/prr_pkg.sv =====
// shared types, constants and codes of the priority round-robin scheduler
`default_nettype none
package prr_pkg;

  localparam int MAX_TASKS_DEF = 16;

  localparam int PRI_W   = 4;
  localparam int BURST_W = 16;
  localparam int TURNS_W = 16;
  localparam int KEY_W   = 16;
  localparam int SLOT_OUT_W = 4;
  localparam int TIME_W  = 32;
  localparam int QUANT_W = 16;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [QUANT_W-1:0] QUANTUM_RST = 16'd10;
  localparam logic [QUANT_W-1:0] QUANTUM_MIN = 16'd1;
  localparam logic [TURNS_W-1:0] TURNS_MAX   = '1;
  localparam logic [TIME_W-1:0]  TIME_MAX    = '1;

  localparam logic REG_QUANTUM = 1'b0;

  localparam logic OP_ADD      = 1'b0;
  localparam logic OP_DISPATCH = 1'b1;

  typedef enum logic [1:0] {
    ST_ADDED      = 2'd0,
    ST_FULL       = 2'd1,
    ST_DISPATCHED = 2'd2,
    ST_EMPTY      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FREE,
    S_SCAN,
    S_DRAIN,
    S_CALC,
    S_WRITE
  } state_t;

  typedef struct packed {
    logic [PRI_W-1:0]   pri;
    logic [BURST_W-1:0] burst;
    logic [TURNS_W-1:0] turns;
    logic [KEY_W-1:0]   key;
  } entry_t;

  typedef struct packed {
    logic clear;
    logic hit;
  } pick_ctl_t;

  typedef struct packed {
    logic   found;
    logic   shared;
    entry_t entry;
  } pick_res_t;

endpackage
`default_nettype wire

// ===== design/prr_table.sv =====
// task table memory with registered read data and per-slot valid flags
`default_nettype none
module prr_table #(
  parameter int MAX_TASKS = prr_pkg::MAX_TASKS_DEF,
  parameter int SLOT_W    = $clog2(MAX_TASKS)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                rd_en,
  input  wire logic [SLOT_W-1:0]   rd_addr,
  output      logic                addr_valid,
  output      logic                hit_r,
  output      logic [SLOT_W-1:0]   rd_slot_r,
  output      prr_pkg::entry_t     rd_data_r,
  input  wire logic                wr_en,
  input  wire logic [SLOT_W-1:0]   wr_addr,
  input  wire prr_pkg::entry_t     wr_data,
  input  wire logic                set_valid,
  input  wire logic                clr_valid
);
  import prr_pkg::*;

  entry_t mem [MAX_TASKS];
  logic [MAX_TASKS-1:0] valid_r;

  assign addr_valid = valid_r[rd_addr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
    rd_slot_r <= rd_addr;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      hit_r   <= 1'b0;
    end else begin
      hit_r <= rd_en && valid_r[rd_addr];
      if (set_valid) begin
        valid_r[wr_addr] <= 1'b1;
      end else if (clr_valid) begin
        valid_r[wr_addr] <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/prr_pick.sv =====
// running winner of a table scan: priority, then turns, then key, then slot
`default_nettype none
module prr_pick #(
  parameter int MAX_TASKS = prr_pkg::MAX_TASKS_DEF,
  parameter int SLOT_W    = $clog2(MAX_TASKS)
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire prr_pkg::pick_ctl_t  ctl,
  input  wire logic [SLOT_W-1:0]   slot,
  input  wire prr_pkg::entry_t     entry,
  output      prr_pkg::pick_res_t  res_r,
  output      logic [SLOT_W-1:0]   best_slot_r
);
  import prr_pkg::*;

  logic take;
  logic same_pri;
  logic beats;

  assign same_pri = entry.pri == res_r.entry.pri;
  assign beats = (entry.turns < res_r.entry.turns) ||
                 ((entry.turns == res_r.entry.turns) && (entry.key < res_r.entry.key));
  assign take = !res_r.found || (entry.pri > res_r.entry.pri) || (same_pri && beats);

  always_ff @(posedge clk) begin
    if (ctl.hit && take) begin
      res_r.entry <= entry;
      best_slot_r <= slot;
    end
    if (!rst_n) begin
      res_r.found  <= 1'b0;
      res_r.shared <= 1'b0;
    end else if (ctl.clear) begin
      res_r.found  <= 1'b0;
      res_r.shared <= 1'b0;
    end else if (ctl.hit) begin
      res_r.found <= 1'b1;
      if (!res_r.found || entry.pri > res_r.entry.pri) begin
        res_r.shared <= 1'b0;
      end else if (same_pri) begin
        res_r.shared <= 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/priority_round_robin_scheduler.sv =====
// top level: command port, quantum register, scan sequencer and result registers
//
// Add commands search the valid flags from slot 0 upward, one slot per cycle. A dispatch
// reads every slot of the task table once, one read per cycle, then computes the slice
// length and writes the winner back. busy is high from the transfer of a command until
// its result is driven; the result shows for one cycle under out_valid in the same cycle
// that busy falls, and the receiver cannot stall it. The quantum register is at byte
// address 0 and is reset to 10; a quantum of zero acts as one.
`default_nettype none
module priority_round_robin_scheduler #(
  parameter int MAX_TASKS = prr_pkg::MAX_TASKS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              start,
  output      logic                              busy,
  input  wire logic                              in_opcode,
  input  wire logic [prr_pkg::PRI_W-1:0]         in_task_priority,
  input  wire logic [prr_pkg::BURST_W-1:0]       in_task_burst,
  input  wire logic [prr_pkg::KEY_W-1:0]         in_name_key,
  output      logic                              out_valid,
  output      logic [1:0]                        out_status,
  output      logic [prr_pkg::SLOT_OUT_W-1:0]    out_slot,
  output      logic [prr_pkg::KEY_W-1:0]         out_name_key,
  output      logic [prr_pkg::BURST_W-1:0]       out_run_length,
  output      logic [prr_pkg::BURST_W-1:0]       out_remaining,
  output      logic                              out_finished,
  output      logic [prr_pkg::TIME_W-1:0]        out_time_now,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [prr_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire logic [prr_pkg::CFG_DATA_W-1:0]    pwdata,
  output      logic [prr_pkg::CFG_DATA_W-1:0]    prdata,
  output      logic                              pready
);
  import prr_pkg::*;

  localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(MAX_TASKS - 1);

  state_t state_r, state_nxt;
  logic [SLOT_W-1:0] idx_r, idx_nxt;
  logic              op_r;
  logic [PRI_W-1:0]   pri_r;
  logic [BURST_W-1:0] burst_r;
  logic [KEY_W-1:0]   key_r;
  logic [QUANT_W-1:0] quantum_r;
  logic [TIME_W-1:0]  elapsed_r, elapsed_nxt;
  logic [BURST_W-1:0] run_r, run_nxt;
  logic [BURST_W-1:0] rem_r, rem_nxt;

  logic               out_valid_r, out_valid_nxt;
  status_t            out_status_r, out_status_nxt;
  logic [SLOT_OUT_W-1:0] out_slot_r, out_slot_nxt;
  logic [KEY_W-1:0]   out_key_r, out_key_nxt;
  logic [BURST_W-1:0] out_run_r, out_run_nxt;
  logic [BURST_W-1:0] out_rem_r, out_rem_nxt;
  logic               out_fin_r, out_fin_nxt;
  logic [TIME_W-1:0]  out_time_r, out_time_nxt;

  logic               accept;
  logic               cfg_wr;
  logic [QUANT_W-1:0] q_eff;
  logic [TIME_W-1:0]  time_sum;
  logic               time_ovf;

  logic              tbl_rd_en;
  logic [SLOT_W-1:0] tbl_rd_addr;
  logic              tbl_addr_valid;
  logic              tbl_hit;
  logic [SLOT_W-1:0] tbl_rd_slot;
  entry_t            tbl_rd_data;
  logic              tbl_wr_en;
  logic [SLOT_W-1:0] tbl_wr_addr;
  entry_t            tbl_wr_data;
  logic              tbl_set_valid;
  logic              tbl_clr_valid;

  pick_ctl_t         pick_ctl;
  pick_res_t         pick_res;
  logic [SLOT_W-1:0] best_slot;

  prr_table #(
    .MAX_TASKS (MAX_TASKS),
    .SLOT_W    (SLOT_W)
  ) u_table (
    .clk        (clk),
    .rst_n      (rst_n),
    .rd_en      (tbl_rd_en),
    .rd_addr    (tbl_rd_addr),
    .addr_valid (tbl_addr_valid),
    .hit_r      (tbl_hit),
    .rd_slot_r  (tbl_rd_slot),
    .rd_data_r  (tbl_rd_data),
    .wr_en      (tbl_wr_en),
    .wr_addr    (tbl_wr_addr),
    .wr_data    (tbl_wr_data),
    .set_valid  (tbl_set_valid),
    .clr_valid  (tbl_clr_valid)
  );

  prr_pick #(
    .MAX_TASKS (MAX_TASKS),
    .SLOT_W    (SLOT_W)
  ) u_pick (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctl         (pick_ctl),
    .slot        (tbl_rd_slot),
    .entry       (tbl_rd_data),
    .res_r       (pick_res),
    .best_slot_r (best_slot)
  );

  assign accept = start && !busy;
  assign busy   = state_r != S_IDLE;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  assign prdata = (paddr[2] == REG_QUANTUM) ? CFG_DATA_W'(quantum_r) : '0;

  assign q_eff = (quantum_r == '0) ? QUANTUM_MIN : quantum_r;
  assign {time_ovf, time_sum} = {1'b0, elapsed_r} + (TIME_W + 1)'(run_r);

  assign pick_ctl.clear = accept;
  assign pick_ctl.hit   = tbl_hit;

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    elapsed_nxt    = elapsed_r;
    run_nxt        = run_r;
    rem_nxt        = rem_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_key_nxt    = out_key_r;
    out_run_nxt    = out_run_r;
    out_rem_nxt    = out_rem_r;
    out_fin_nxt    = out_fin_r;
    out_time_nxt   = out_time_r;
    tbl_rd_en      = 1'b0;
    tbl_rd_addr    = idx_r;
    tbl_wr_en      = 1'b0;
    tbl_wr_addr    = idx_r;
    tbl_wr_data    = '{pri: pri_r, burst: burst_r, turns: '0, key: key_r};
    tbl_set_valid  = 1'b0;
    tbl_clr_valid  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          idx_nxt   = '0;
          state_nxt = (in_opcode == OP_ADD) ? S_FREE : S_SCAN;
        end
      end
      S_FREE: begin
        if (!tbl_addr_valid) begin
          tbl_wr_en      = 1'b1;
          tbl_set_valid  = 1'b1;
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_ADDED;
          out_slot_nxt   = SLOT_OUT_W'(idx_r);
          out_key_nxt    = '0;
          out_run_nxt    = '0;
          out_rem_nxt    = '0;
          out_fin_nxt    = 1'b0;
          out_time_nxt   = elapsed_r;
          state_nxt      = S_IDLE;
        end else if (idx_r == LAST_SLOT) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_FULL;
          out_slot_nxt   = '0;
          out_key_nxt    = '0;
          out_run_nxt    = '0;
          out_rem_nxt    = '0;
          out_fin_nxt    = 1'b0;
          out_time_nxt   = elapsed_r;
          state_nxt      = S_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_SCAN: begin
        tbl_rd_en = 1'b1;
        if (idx_r == LAST_SLOT) begin
          state_nxt = S_DRAIN;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      S_DRAIN: begin
        state_nxt = S_CALC;
      end
      S_CALC: begin
        if (!pick_res.found) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_EMPTY;
          out_slot_nxt   = '0;
          out_key_nxt    = '0;
          out_run_nxt    = '0;
          out_rem_nxt    = '0;
          out_fin_nxt    = 1'b0;
          out_time_nxt   = elapsed_r;
          state_nxt      = S_IDLE;
        end else begin
          run_nxt = (pick_res.shared && pick_res.entry.burst > q_eff) ?
                    q_eff : pick_res.entry.burst;
          rem_nxt = pick_res.entry.burst - run_nxt;
          state_nxt = S_WRITE;
        end
      end
      S_WRITE: begin
        tbl_wr_en   = 1'b1;
        tbl_wr_addr = best_slot;
        tbl_wr_data = '{pri:   pick_res.entry.pri,
                        burst: rem_r,
                        turns: (pick_res.entry.turns == TURNS_MAX) ?
                               TURNS_MAX : pick_res.entry.turns + 1'b1,
                        key:   pick_res.entry.key};
        tbl_clr_valid  = rem_r == '0;
        elapsed_nxt    = time_ovf ? TIME_MAX : time_sum;
        out_valid_nxt  = 1'b1;
        out_status_nxt = ST_DISPATCHED;
        out_slot_nxt   = SLOT_OUT_W'(best_slot);
        out_key_nxt    = pick_res.entry.key;
        out_run_nxt    = run_r;
        out_rem_nxt    = rem_r;
        out_fin_nxt    = rem_r == '0;
        out_time_nxt   = elapsed_nxt;
        state_nxt      = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      quantum_r   <= QUANTUM_RST;
      elapsed_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      idx_r       <= idx_nxt;
      elapsed_r   <= elapsed_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && paddr[2] == REG_QUANTUM) begin
        quantum_r <= pwdata[QUANT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_opcode;
      pri_r   <= in_task_priority;
      burst_r <= in_task_burst;
      key_r   <= in_name_key;
    end
    run_r        <= run_nxt;
    rem_r        <= rem_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_key_r    <= out_key_nxt;
    out_run_r    <= out_run_nxt;
    out_rem_r    <= out_rem_nxt;
    out_fin_r    <= out_fin_nxt;
    out_time_r   <= out_time_nxt;
  end

  assign out_valid      = out_valid_r && (op_r == OP_ADD || op_r == OP_DISPATCH);
  assign out_status     = out_status_r;
  assign out_slot       = out_slot_r;
  assign out_name_key   = out_key_r;
  assign out_run_length = out_run_r;
  assign out_remaining  = out_rem_r;
  assign out_finished   = out_fin_r;
  assign out_time_now   = out_time_r;

endmodule
`default_nettype wire

// ===== design/prr_checker.sv =====
// port-level checks of the scheduler and their bind to the top level
`default_nettype none
module prr_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           start,
  input wire logic                           busy,
  input wire logic                           out_valid,
  input wire logic [1:0]                     out_status,
  input wire logic [prr_pkg::SLOT_OUT_W-1:0] out_slot,
  input wire logic [prr_pkg::BURST_W-1:0]    out_run_length,
  input wire logic [prr_pkg::BURST_W-1:0]    out_remaining,
  input wire logic                           out_finished
);
  import prr_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after command transfer");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  a_no_task_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_FULL || out_status == ST_EMPTY) |->
      out_slot == '0 && out_run_length == '0 && out_remaining == '0 && !out_finished)
    else $error("full or empty result carries task fields");

  a_finish_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_DISPATCHED |-> out_finished == (out_remaining == '0))
    else $error("finished flag disagrees with remaining burst");

  a_add_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ST_ADDED |->
      out_run_length == '0 && out_remaining == '0 && !out_finished)
    else $error("add result carries dispatch fields");

endmodule

bind priority_round_robin_scheduler prr_checker u_prr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .start          (start),
  .busy           (busy),
  .out_valid      (out_valid),
  .out_status     (out_status),
  .out_slot       (out_slot),
  .out_run_length (out_run_length),
  .out_remaining  (out_remaining),
  .out_finished   (out_finished)
);
`default_nettype wire

// ===== tb/testbench.sv =====
// self-checking testbench of the priority round-robin scheduler: directed table, fill and drain, then random
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import prr_pkg::*;

  localparam int NUM_SLOTS  = MAX_TASKS_DEF;
  localparam int ITEMS_EACH = 250;

  typedef struct packed {
    logic               op;
    logic [PRI_W-1:0]   pri;
    logic [BURST_W-1:0] burst;
    logic [KEY_W-1:0]   key;
  } command_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [KEY_W-1:0]      key;
    logic [BURST_W-1:0]    run;
    logic [BURST_W-1:0]    rem;
    logic                  fin;
    logic [TIME_W-1:0]     tnow;
  } outcome_t;

  typedef struct packed {
    command_t cmd;
    logic     typed;
    outcome_t res;
  } step_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_opcode = OP_ADD;
  logic [PRI_W-1:0] in_task_priority = '0;
  logic [BURST_W-1:0] in_task_burst = '0;
  logic [KEY_W-1:0] in_name_key = '0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;

  logic busy, out_valid, out_finished, pready;
  logic [1:0] out_status;
  logic [SLOT_OUT_W-1:0] out_slot;
  logic [KEY_W-1:0] out_name_key;
  logic [BURST_W-1:0] out_run_length, out_remaining;
  logic [TIME_W-1:0] out_time_now;
  logic [CFG_DATA_W-1:0] prdata;

  priority_round_robin_scheduler #(.MAX_TASKS(NUM_SLOTS)) u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_task_priority(in_task_priority),
    .in_task_burst(in_task_burst), .in_name_key(in_name_key),
    .out_valid(out_valid), .out_status(out_status), .out_slot(out_slot),
    .out_name_key(out_name_key), .out_run_length(out_run_length),
    .out_remaining(out_remaining), .out_finished(out_finished),
    .out_time_now(out_time_now),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #1 clk = ~clk;

  // scheduler shadow state
  logic [NUM_SLOTS-1:0] tbl_valid = '0;
  logic [PRI_W-1:0]     tbl_pri   [NUM_SLOTS];
  logic [BURST_W-1:0]   tbl_burst [NUM_SLOTS];
  logic [TURNS_W-1:0]   tbl_turns [NUM_SLOTS];
  logic [KEY_W-1:0]     tbl_key   [NUM_SLOTS];
  logic [TIME_W-1:0]    sched_time = '0;
  logic [QUANT_W-1:0]   cur_quantum = QUANTUM_RST;

  outcome_t pending_outcomes [$];
  outcome_t head;
  int errors = 0;
  int cmds_sent = 0;
  int n_added = 0, n_full = 0, n_slices = 0, n_empty = 0, n_finished = 0;

  step_row_t directed_rows [18] = '{
    '{'{OP_DISPATCH, 4'd0, 16'd0, 16'd0}, 1'b1,
      '{ST_EMPTY, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd0}},
    '{'{OP_ADD, 4'd15, 16'hFFFF, 16'd0}, 1'b1,
      '{ST_ADDED, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd0}},
    '{'{OP_DISPATCH, 4'd0, 16'd0, 16'd0}, 1'b1,
      '{ST_DISPATCHED, 4'd0, 16'd0, 16'hFFFF, 16'd0, 1'b1, 32'd65535}},
    '{'{OP_ADD, 4'd0, 16'd0, 16'hFFFF}, 1'b1,
      '{ST_ADDED, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd65535}},
    '{'{OP_DISPATCH, 4'd15, 16'hFFFF, 16'hFFFF}, 1'b1,
      '{ST_DISPATCHED, 4'd0, 16'hFFFF, 16'd0, 16'd0, 1'b1, 32'd65535}},
    '{'{OP_ADD, 4'd7, 16'd25, 16'd5}, 1'b1,
      '{ST_ADDED, 4'd0, 16'd0, 16'd0, 16'd0, 1'b0, 32'd65535}},
    '{'{OP_ADD, 4'd7, 16'd25, 16'd3}, 1'b1,
      '{ST_ADDED, 4'd1, 16'd0, 16'd0, 16'd0, 1'b0, 32'd65535}},
    '{'{OP_ADD, 4'd7, 16'd4, 16'd3}, 1'b1,
      '{ST_ADDED, 4'd2, 16'd0, 16'd0, 16'd0, 1'b0, 32'd65535}},
    '{'{OP_ADD, 4'd3, 16'd30, 16'd0}, 1'b0, '0},
    '{'{OP_DISPATCH, 4'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{OP_DISPATCH, 4'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{OP_DISPATCH, 4'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{OP_DISPATCH, 4'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{OP_DISPATCH, 4'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{OP_DISPATCH, 4'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{OP_DISPATCH, 4'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{OP_DISPATCH, 4'd0, 16'd0, 16'd0}, 1'b0, '0},
    '{'{OP_DISPATCH, 4'd0, 16'd0, 16'd0}, 1'b0, '0}
  };

  function automatic bit outranks(int a, int b);
    if (tbl_turns[a] != tbl_turns[b]) return tbl_turns[a] < tbl_turns[b];
    if (tbl_key[a] != tbl_key[b]) return tbl_key[a] < tbl_key[b];
    return a < b;
  endfunction

  function automatic outcome_t schedule_command(command_t c);
    outcome_t r;
    int best;
    bit found, shared;
    logic [QUANT_W-1:0] q;
    logic [BURST_W-1:0] run, rem;
    logic [TIME_W:0] sum;
    r = '0;
    r.tnow = sched_time;
    if (c.op == OP_ADD) begin
      r.status = ST_FULL;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (!tbl_valid[i]) begin
          tbl_valid[i] = 1'b1;
          tbl_pri[i] = c.pri;
          tbl_burst[i] = c.burst;
          tbl_turns[i] = '0;
          tbl_key[i] = c.key;
          r.status = ST_ADDED;
          r.slot = SLOT_OUT_W'(i);
          return r;
        end
      end
      return r;
    end
    found = 1'b0;
    shared = 1'b0;
    best = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (tbl_valid[i]) begin
        if (!found) begin
          found = 1'b1;
          best = i;
          shared = 1'b0;
        end else if (tbl_pri[i] > tbl_pri[best]) begin
          best = i;
          shared = 1'b0;
        end else if (tbl_pri[i] == tbl_pri[best]) begin
          shared = 1'b1;
          if (outranks(i, best)) best = i;
        end
      end
    end
    if (!found) begin
      r.status = ST_EMPTY;
      return r;
    end
    q = (cur_quantum == '0) ? QUANTUM_MIN : cur_quantum;
    run = (shared && tbl_burst[best] > q) ? q : tbl_burst[best];
    rem = tbl_burst[best] - run;
    if (tbl_turns[best] != TURNS_MAX) tbl_turns[best] = tbl_turns[best] + 1'b1;
    tbl_burst[best] = rem;
    if (rem == '0) tbl_valid[best] = 1'b0;
    sum = {1'b0, sched_time} + run;
    sched_time = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
    r.status = ST_DISPATCHED;
    r.slot = SLOT_OUT_W'(best);
    r.key = tbl_key[best];
    r.run = run;
    r.rem = rem;
    r.fin = (rem == '0);
    r.tnow = sched_time;
    return r;
  endfunction

  function automatic command_t make_random_command(int add_pct);
    command_t c;
    int pick;
    c.op = ($urandom_range(0, 99) < add_pct) ? OP_ADD : OP_DISPATCH;
    c.pri = ($urandom_range(0, 99) < 60) ? PRI_W'($urandom_range(0, 3)) : PRI_W'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 5) c.burst = '0;
    else if (pick < 10) c.burst = '1;
    else if (pick < 20) c.burst = BURST_W'($urandom);
    else c.burst = BURST_W'($urandom_range(1, 40));
    c.key = ($urandom_range(0, 1) == 0) ? KEY_W'($urandom_range(0, 7)) : KEY_W'($urandom);
    return c;
  endfunction

  function automatic void compare_field(string what, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    end
  endfunction

  // when idle_ok is set, start idles at random cycle by cycle until the command is transferred
  task automatic issue_command(command_t c, bit idle_ok, bit typed, outcome_t typed_res);
    outcome_t predicted;
    in_opcode <= c.op;
    in_task_priority <= c.pri;
    in_task_burst <= c.burst;
    in_name_key <= c.key;
    do begin
      start <= !(idle_ok && $urandom_range(0, 99) < 17);
      @(posedge clk);
    end while (!(start && !busy));
    predicted = schedule_command(c);
    pending_outcomes.push_back(typed ? typed_res : predicted);
    cmds_sent++;
  endtask

  task automatic wait_for_quiet();
    start <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  // write the quantum, then read it back in the following access
  task automatic set_quantum(logic [QUANT_W-1:0] q);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= CFG_ADDR_W'(4 * REG_QUANTUM);
    pwdata <= {16'($urandom), q};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cur_quantum = q;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    compare_field("quantum readback", {16'd0, q}, prdata);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      case (out_status)
        ST_ADDED: n_added++;
        ST_FULL: n_full++;
        ST_DISPATCHED: n_slices++;
        default: n_empty++;
      endcase
      if (out_finished) n_finished++;
      if (pending_outcomes.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, got status %0d slot %0d",
                 $time, out_status, out_slot);
      end else begin
        head = pending_outcomes.pop_front();
        compare_field("status", 32'(head.status), 32'(out_status));
        compare_field("slot", 32'(head.slot), 32'(out_slot));
        compare_field("name_key", 32'(head.key), 32'(out_name_key));
        compare_field("run_length", 32'(head.run), 32'(out_run_length));
        compare_field("remaining", 32'(head.rem), 32'(out_remaining));
        compare_field("finished", 32'(head.fin), 32'(out_finished));
        compare_field("time_now", head.tnow, out_time_now);
      end
    end
  end

  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", pending_outcomes.size());
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int add_pct;
    logic [QUANT_W-1:0] quanta [6];
    command_t c;
    quanta = '{QUANTUM_MIN, 16'hFFFF, 16'd0, 16'd3, QUANT_W'($urandom_range(2, 65534)),
               QUANTUM_RST};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[n]) begin
      issue_command(directed_rows[n].cmd, 1'b1, directed_rows[n].typed, directed_rows[n].res);
    end

    // fill the table past full, then drain it to empty
    for (int n = 0; n < NUM_SLOTS + 1; n++) begin
      c.op = OP_ADD;
      c.pri = PRI_W'($urandom);
      c.burst = BURST_W'($urandom_range(1, 3));
      c.key = KEY_W'($urandom);
      issue_command(c, 1'b1, 1'b0, '0);
    end
    issue_command('{OP_ADD, 4'd15, 16'hFFFF, 16'hFFFF}, 1'b1, 1'b0, '0);
    while (tbl_valid != '0) issue_command('{OP_DISPATCH, 4'd0, 16'd0, 16'd0}, 1'b1, 1'b0, '0);
    issue_command('{OP_DISPATCH, 4'hF, 16'hFFFF, 16'hFFFF}, 1'b1, 1'b0, '0);

    for (int ph = 0; ph < 6; ph++) begin
      wait_for_quiet();
      set_quantum(quanta[ph]);
      add_pct = 50;
      for (int k = 0; k < ITEMS_EACH; k++) begin
        if (k % 30 == 0) add_pct = ($urandom_range(0, 1) == 0) ? 75 : 30;
        issue_command(make_random_command(add_pct), ph != 1, 1'b0, '0);
        if ($urandom_range(0, 99) < 2) wait_for_quiet();
      end
    end

    wait_for_quiet();
    repeat (NUM_SLOTS + 8) @(posedge clk);
    $display("sent %0d commands over six random quantum phases, including zero and both extremes",
             cmds_sent);
    $display("results: %0d added, %0d full, %0d slices (%0d finished), %0d empty",
             n_added, n_full, n_slices, n_finished, n_empty);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
design/prr_pkg.sv
design/prr_table.sv
design/prr_pick.sv
design/priority_round_robin_scheduler.sv
design/prr_checker.sv
tb/testbench.sv
